/* design/stmp_pkg.sv */
package stmp_pkg;

    // Set to 1 to mirror the pulse mapping (180 degrees minus the angle).
    localparam logic INVERT = 1'b0;

    localparam int MUL_W = 24;
    localparam int DIV_W = 48;
    localparam int SQRT_STEPS = 23;

    localparam logic [23:0] SOFT_THRESH = 24'd3276;
    localparam logic [31:0] IDLE_CAP    = 32'hFFFF0000;
    localparam logic [23:0] DEG180_Q16  = 24'd11796480;
    localparam logic [37:0] HALF_180    = 38'd5898240;
    localparam logic [15:0] DEF_SPEED   = 16'd1000;
    localparam logic [19:0] DEF_ACCEL   = 20'd100000;
    localparam logic [10:0] DIVISOR_MS  = 11'd1000;
    localparam logic [10:0] DIVISOR_DEG = 11'd180;
    localparam logic [47:0] ROUND_UP_MS = 48'd999;

    typedef enum logic [2:0] {
        REG_PRESSED  = 3'd0,
        REG_RELEASED = 3'd1,
        REG_SPEED    = 3'd2,
        REG_ACCEL    = 3'd3,
        REG_DET_EN   = 3'd4,
        REG_DET_DLY  = 3'd5,
        REG_MIN_PULSE = 3'd6,
        REG_MAX_PULSE = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_TARGET = 2'd1,
        MODE_FORCE  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Control for the serial divider: start a run, and pick the divisor.
    typedef struct packed {
        logic start;
        logic by180;
    } div_ctl_t;

endpackage

/* design/stmp_mul.sv */
module stmp_mul
    import stmp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MUL_W-1:0]     mcand,
    input  logic [MUL_W-1:0]     mplier,
    output logic                 done,
    output logic [2*MUL_W-1:0]   prod
);

    // Shift-add multiplier: one multiplier bit per cycle, LSB first.
    logic [MUL_W-1:0]   mcand_reg;
    logic [2*MUL_W-1:0] prod_reg;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_W:0]     sum;

    assign sum  = {1'b0, prod_reg[2*MUL_W-1:MUL_W]}
                + {1'b0, (prod_reg[0] ? mcand_reg : {MUL_W{1'b0}})};
    assign done = done_reg;
    assign prod = prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(MUL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= mcand;
            prod_reg  <= {{MUL_W{1'b0}}, mplier};
        end else if (busy_reg) begin
            prod_reg <= {sum, prod_reg[MUL_W-1:1]};
        end
    end

endmodule

/* design/stmp_div.sv */
module stmp_div
    import stmp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctl_t         ctl,
    input  logic [DIV_W-1:0] dividend,
    output logic             done,
    output logic [DIV_W-1:0] quo
);

    // Restoring division by a small constant, one quotient bit per cycle.
    logic [DIV_W-1:0] q_reg;
    logic [9:0]       rem_reg;
    logic             by180_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [10:0]      trial;
    logic [10:0]      divisor;
    logic             ge;
    logic [10:0]      diff;

    assign trial   = {rem_reg, q_reg[DIV_W-1]};
    assign divisor = by180_reg ? DIVISOR_DEG : DIVISOR_MS;
    assign ge      = trial >= divisor;
    assign diff    = trial - divisor;
    assign done    = done_reg;
    assign quo     = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            q_reg     <= dividend;
            rem_reg   <= '0;
            by180_reg <= ctl.by180;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[9:0] : trial[9:0];
        end
    end

endmodule

/* design/servo_trapezoid_motion_profile.sv */
// Trapezoidal motion profiler for a hobby servo that swings between two
// calibrated angles (pressed and released).
// Input channel (s_): one transaction per command. s_tuser carries the mode
// (time tick, soft target change, forced jump); s_tdata carries the press
// selector and the tick length in milliseconds.
// Output channel (m_): exactly one transaction per input transaction, with
// the servo pulse width, the current angle in Q16 degrees, the motion flag,
// the selected position and the detach request.
// Configuration goes through the APB port; every write reloads the motion
// state to rest at the released angle. Writes belong to idle periods.
// One command is handled at a time. A tick during motion runs three serial
// multiplies, two serial divides by 1000, a square root and the pulse
// conversion. Every other command only runs the pulse conversion (one
// serial multiply and one serial divide by 180).
// Reset clears the output channel and puts the servo at rest at 0 degrees
// with default pulse limits of 500 and 2500 us.
// A finished result sits in the output register; the next command is taken
// while it waits, but its own result is held back until m_tready frees it.
module servo_trapezoid_motion_profile
    import stmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input transactions.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // press [0], elapsed_ms [16:1], zero pad
    input  logic [1:0]  s_tuser,   // mode [1:0]
    // Result transactions.
    output logic        m_tvalid,
    input  logic        m_tready,
    // pulse_us [11:0], angle_now [35:12], in_motion [36], is_pressed [37],
    // detach_request [38], zero pad [39]
    output logic [39:0] m_tdata,
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // One-hot sequencer. The tick path walks through the arithmetic steps in
    // order; every command ends in the pulse conversion and the output load.
    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_MACC   = 11'b00000000010,
        ST_DACC   = 11'b00000000100,
        ST_MSTOP  = 11'b00000001000,
        ST_SQRT   = 11'b00000010000,
        ST_MSTEP  = 11'b00000100000,
        ST_DSTEP  = 11'b00001000000,
        ST_PSTART = 11'b00010000000,
        ST_MPULSE = 11'b00100000000,
        ST_DPULSE = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0]  pressed_reg, pressed_next;
    logic [7:0]  released_reg, released_next;
    logic [15:0] speed_reg, speed_next;
    logic [19:0] accel_reg, accel_next;
    logic        det_en_reg, det_en_next;
    logic [15:0] det_dly_reg, det_dly_next;
    logic [11:0] min_pulse_reg, min_pulse_next;
    logic [11:0] max_pulse_reg, max_pulse_next;

    // Motion state.
    logic [23:0] angle_reg, angle_next;
    logic [7:0]  target_reg, target_next;
    logic [23:0] vel_reg, vel_next;
    logic        moving_reg, moving_next;
    logic        pressed_flag_reg, pressed_flag_next;
    logic [31:0] idle_reg, idle_next;

    // Working registers for one command.
    logic [15:0] ms_reg, ms_next;
    logic        up_reg, up_next;
    logic [23:0] dist_reg, dist_next;
    logic [36:0] sum_reg, sum_next;
    logic [23:0] spd_reg, spd_next;
    logic [45:0] rad_reg, rad_next;
    logic [22:0] root_reg, root_next;
    logic [23:0] rem_reg, rem_next;
    logic [4:0]  sq_cnt_reg, sq_cnt_next;
    logic        neg_reg, neg_next;
    logic [11:0] pulse_reg, pulse_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg, m_data_next;

    // Shared arithmetic units.
    logic                 mul_start;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic                 mul_done;
    logic [2*MUL_W-1:0]   mul_prod;
    div_ctl_t             div_ctl;
    logic [DIV_W-1:0]     div_dvd;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;

    stmp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    stmp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dvd),
        .done     (div_done),
        .quo      (div_quo)
    );

    // Input fields.
    mode_t       in_mode;
    logic        in_press;
    logic [15:0] in_ms;

    assign in_mode  = mode_t'(s_tuser);
    assign in_press = s_tdata[0];
    assign in_ms    = s_tdata[16:1];

    // Configuration port.
    logic     cfg_wr;
    cfg_reg_t cfg_idx;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_reg_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_PRESSED:   prdata = 32'(pressed_reg);
            REG_RELEASED:  prdata = 32'(released_reg);
            REG_SPEED:     prdata = 32'(speed_reg);
            REG_ACCEL:     prdata = 32'(accel_reg);
            REG_DET_EN:    prdata = 32'(det_en_reg);
            REG_DET_DLY:   prdata = 32'(det_dly_reg);
            REG_MIN_PULSE: prdata = 32'(min_pulse_reg);
            REG_MAX_PULSE: prdata = 32'(max_pulse_reg);
            default:       prdata = '0;
        endcase
    end

    // Effective limits: a zero register selects the default.
    logic [19:0] acc_eff;
    logic [23:0] vmax;

    assign acc_eff = (accel_reg == '0) ? DEF_ACCEL : accel_reg;
    assign vmax    = {((speed_reg == '0) ? DEF_SPEED : speed_reg), 8'h00};

    // Distance to the current target.
    logic [23:0] tq;
    logic        up_now;
    logic [23:0] dist_now;

    assign tq       = {target_reg, 16'h0000};
    assign up_now   = tq >= angle_reg;
    assign dist_now = up_now ? (tq - angle_reg) : (angle_reg - tq);

    // Distance to a newly selected target, for the soft threshold.
    logic [7:0]  sel_deg;
    logic [23:0] sel_q16;
    logic [23:0] sel_dist;

    assign sel_deg  = in_press ? pressed_reg : released_reg;
    assign sel_q16  = {sel_deg, 16'h0000};
    assign sel_dist = (sel_q16 >= angle_reg) ? (sel_q16 - angle_reg)
                                             : (angle_reg - sel_q16);

    // One digit of the square root: two radicand bits in, one root bit out.
    logic [25:0] sq_rem;
    logic [25:0] sq_trial;
    logic        sq_ge;
    logic [22:0] sq_root;
    logic [23:0] sq_rem_new;

    assign sq_rem     = {rem_reg, rad_reg[45:44]};
    assign sq_trial   = {1'b0, root_reg, 2'b01};
    assign sq_ge      = sq_rem >= sq_trial;
    assign sq_root    = {root_reg[21:0], sq_ge};
    assign sq_rem_new = sq_ge ? 24'(sq_rem - sq_trial) : sq_rem[23:0];

    // Speed after the acceleration step, capped by the limit and the
    // stopping speed from the finished root.
    logic [23:0] spd_lim;
    logic [23:0] spd_cap;

    assign spd_lim = (sum_reg > 37'(vmax)) ? vmax : sum_reg[23:0];
    assign spd_cap = (spd_lim > 24'(sq_root)) ? 24'(sq_root) : spd_lim;

    // Position update and clamp to the calibrated travel.
    logic        snap;
    logic [23:0] ang_step;
    logic [23:0] lo_q16, hi_q16;
    logic [23:0] ang_clamped;

    assign snap     = div_quo >= 48'(dist_reg);
    assign ang_step = snap ? tq
                    : (up_reg ? angle_reg + div_quo[23:0] : angle_reg - div_quo[23:0]);
    assign lo_q16   = {((pressed_reg < released_reg) ? pressed_reg : released_reg), 16'h0};
    assign hi_q16   = {((pressed_reg > released_reg) ? pressed_reg : released_reg), 16'h0};
    assign ang_clamped = (ang_step < lo_q16) ? lo_q16
                       : ((ang_step > hi_q16) ? hi_q16 : ang_step);

    // Pulse mapping: angle clamped to the half turn, times the pulse span.
    logic [24:0] a_pre;
    logic [23:0] a_clip;
    logic [12:0] span;
    logic [12:0] span_mag;
    logic [37:0] base;
    logic [38:0] pnum;

    assign a_pre    = INVERT ? ({1'b0, DEG180_Q16} - {1'b0, angle_reg}) : {1'b0, angle_reg};
    assign a_clip   = a_pre[24] ? 24'd0
                    : ((a_pre[23:0] > DEG180_Q16) ? DEG180_Q16 : a_pre[23:0]);
    assign span     = {1'b0, max_pulse_reg} - {1'b0, min_pulse_reg};
    assign span_mag = span[12] ? (13'd0 - span) : span;
    // min_pulse * 180 by shifts: 128 + 32 + 16 + 4.
    assign base     = {(20'(min_pulse_reg) << 7) + (20'(min_pulse_reg) << 5)
                     + (20'(min_pulse_reg) << 4) + (20'(min_pulse_reg) << 2), 16'h0}
                    + 38'(HALF_180) - 38'(HALF_180) + HALF_180;
    assign pnum     = neg_reg ? ({1'b0, base} - {1'b0, mul_prod[37:0]})
                              : ({1'b0, base} + {1'b0, mul_prod[37:0]});

    logic detach;
    assign detach = det_en_reg && !moving_reg && (idle_reg >= 32'(det_dly_reg));

    always_comb begin
        state_next        = state_reg;
        pressed_next      = pressed_reg;
        released_next     = released_reg;
        speed_next        = speed_reg;
        accel_next        = accel_reg;
        det_en_next       = det_en_reg;
        det_dly_next      = det_dly_reg;
        min_pulse_next    = min_pulse_reg;
        max_pulse_next    = max_pulse_reg;
        angle_next        = angle_reg;
        target_next       = target_reg;
        vel_next          = vel_reg;
        moving_next       = moving_reg;
        pressed_flag_next = pressed_flag_reg;
        idle_next         = idle_reg;
        ms_next           = ms_reg;
        up_next           = up_reg;
        dist_next         = dist_reg;
        sum_next          = sum_reg;
        spd_next          = spd_reg;
        rad_next          = rad_reg;
        root_next         = root_reg;
        rem_next          = rem_reg;
        sq_cnt_next       = sq_cnt_reg;
        neg_next          = neg_reg;
        pulse_next        = pulse_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        mul_start         = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        div_ctl           = '0;
        div_dvd           = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ms_next    = in_ms;
                    state_next = ST_PSTART;
                    case (in_mode)
                        MODE_TICK: begin
                            if (in_ms != '0 && moving_reg) begin
                                mul_start  = 1'b1;
                                mul_a      = 24'(acc_eff);
                                mul_b      = 24'(in_ms);
                                state_next = ST_MACC;
                            end else if (in_ms != '0 && idle_reg < IDLE_CAP) begin
                                idle_next = idle_reg + 32'(in_ms);
                            end
                        end
                        MODE_TARGET: begin
                            pressed_flag_next = in_press;
                            target_next       = sel_deg;
                            if (sel_dist > SOFT_THRESH) begin
                                moving_next = 1'b1;
                                idle_next   = '0;
                            end
                        end
                        MODE_FORCE: begin
                            pressed_flag_next = in_press;
                            target_next       = sel_deg;
                            angle_next        = sel_q16;
                            vel_next          = '0;
                            moving_next       = 1'b0;
                            idle_next         = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MACC: begin
                if (mul_done) begin
                    div_ctl.start = 1'b1;
                    div_dvd       = {mul_prod[39:0], 8'h00};
                    state_next    = ST_DACC;
                end
            end
            ST_DACC: begin
                if (div_done) begin
                    sum_next   = 37'(vel_reg) + 37'(div_quo[35:0]);
                    up_next    = up_now;
                    dist_next  = dist_now;
                    mul_start  = 1'b1;
                    mul_a      = 24'(acc_eff);
                    mul_b      = dist_now;
                    state_next = ST_MSTOP;
                end
            end
            ST_MSTOP: begin
                if (mul_done) begin
                    rad_next    = {mul_prod[44:0], 1'b0};
                    root_next   = '0;
                    rem_next    = '0;
                    sq_cnt_next = '0;
                    state_next  = ST_SQRT;
                end
            end
            ST_SQRT: begin
                rad_next    = {rad_reg[43:0], 2'b00};
                root_next   = sq_root;
                rem_next    = sq_rem_new;
                sq_cnt_next = sq_cnt_reg + 5'd1;
                if (sq_cnt_reg == 5'(SQRT_STEPS - 1)) begin
                    spd_next   = spd_cap;
                    mul_start  = 1'b1;
                    mul_a      = spd_cap;
                    mul_b      = 24'(ms_reg);
                    state_next = ST_MSTEP;
                end
            end
            ST_MSTEP: begin
                if (mul_done) begin
                    div_ctl.start = 1'b1;
                    div_dvd       = {mul_prod[39:0], 8'h00} + ROUND_UP_MS;
                    state_next    = ST_DSTEP;
                end
            end
            ST_DSTEP: begin
                if (div_done) begin
                    angle_next = ang_clamped;
                    if (snap) begin
                        vel_next    = '0;
                        moving_next = 1'b0;
                        idle_next   = '0;
                    end else begin
                        vel_next = spd_reg;
                    end
                    state_next = ST_PSTART;
                end
            end
            ST_PSTART: begin
                mul_start  = 1'b1;
                mul_a      = a_clip;
                mul_b      = 24'(span_mag);
                neg_next   = span[12];
                state_next = ST_MPULSE;
            end
            ST_MPULSE: begin
                if (mul_done) begin
                    div_ctl.start = 1'b1;
                    div_ctl.by180 = 1'b1;
                    div_dvd       = pnum[38] ? '0 : 48'(pnum[37:16]);
                    state_next    = ST_DPULSE;
                end
            end
            ST_DPULSE: begin
                if (div_done) begin
                    pulse_next = div_quo[11:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, detach, pressed_flag_reg, moving_reg,
                                    angle_reg, pulse_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write puts the servo back at rest on the released angle.
        if (cfg_wr) begin
            case (cfg_idx)
                REG_PRESSED:   pressed_next   = pwdata[7:0];
                REG_RELEASED:  released_next  = pwdata[7:0];
                REG_SPEED:     speed_next     = pwdata[15:0];
                REG_ACCEL:     accel_next     = pwdata[19:0];
                REG_DET_EN:    det_en_next    = pwdata[0];
                REG_DET_DLY:   det_dly_next   = pwdata[15:0];
                REG_MIN_PULSE: min_pulse_next = pwdata[11:0];
                REG_MAX_PULSE: max_pulse_next = pwdata[11:0];
                default: begin
                end
            endcase
            angle_next        = {released_next, 16'h0000};
            target_next       = released_next;
            vel_next          = '0;
            moving_next       = 1'b0;
            pressed_flag_next = 1'b0;
            idle_next         = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            pressed_reg      <= '0;
            released_reg     <= '0;
            speed_reg        <= '0;
            accel_reg        <= '0;
            det_en_reg       <= 1'b0;
            det_dly_reg      <= '0;
            min_pulse_reg    <= 12'd500;
            max_pulse_reg    <= 12'd2500;
            angle_reg        <= '0;
            target_reg       <= '0;
            vel_reg          <= '0;
            moving_reg       <= 1'b0;
            pressed_flag_reg <= 1'b0;
            idle_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            pressed_reg      <= pressed_next;
            released_reg     <= released_next;
            speed_reg        <= speed_next;
            accel_reg        <= accel_next;
            det_en_reg       <= det_en_next;
            det_dly_reg      <= det_dly_next;
            min_pulse_reg    <= min_pulse_next;
            max_pulse_reg    <= max_pulse_next;
            angle_reg        <= angle_next;
            target_reg       <= target_next;
            vel_reg          <= vel_next;
            moving_reg       <= moving_next;
            pressed_flag_reg <= pressed_flag_next;
            idle_reg         <= idle_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ms_reg     <= ms_next;
        up_reg     <= up_next;
        dist_reg   <= dist_next;
        sum_reg    <= sum_next;
        spd_reg    <= spd_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        sq_cnt_reg <= sq_cnt_next;
        neg_reg    <= neg_next;
        pulse_reg  <= pulse_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* design/stmp_chk.sv */
module stmp_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // The output channel is empty right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One command at a time: right after an accept the input is closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in work");

    // A detach is never requested while the servo is moving.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[36] && m_tdata[38]))
        else $error("detach requested during motion");

endmodule

bind servo_trapezoid_motion_profile stmp_chk u_stmp_chk (.*);

/* test/servo_trapezoid_motion_profile_tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the trapezoidal servo profiler. Commands go in on
// the s_ stream, one result per command comes back on the m_ stream. A
// predictor written inside the bench follows every accepted command and
// queues the expected result; the monitor compares each result transaction
// against the oldest queued expectation, field by field.
module servo_trapezoid_motion_profile_tb;
    import stmp_pkg::*;

    localparam int TOTAL_CMDS = 1950;
    localparam int QUIET_TAIL = 150;

    // Expected content of one result transaction.
    typedef struct {
        logic [11:0] pulse_us;
        logic [23:0] angle_now;
        bit          in_motion;
        bit          is_pressed;
        bit          detach_request;
    } servo_out_t;

    // One row of the directed table. Rows with typed set carry a hand-written
    // expectation; the others are checked against the predictor.
    typedef struct {
        mode_t       mode;
        bit          press;
        logic [15:0] ms;
        bit          typed;
        servo_out_t  want;
    } cmd_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // press [0], elapsed_ms [16:1], zero pad
    logic [1:0]  s_tuser = '0;   // mode [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    // pulse_us [11:0], angle_now [35:12], in_motion [36], is_pressed [37],
    // detach_request [38], zero pad [39]
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    servo_trapezoid_motion_profile i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the configuration and motion state.
    logic [7:0]  cal_pressed, cal_released;
    logic [15:0] cal_speed, cal_delay;
    logic [19:0] cal_accel;
    bit          cal_det_en;
    logic [11:0] cal_min_pulse, cal_max_pulse;

    logic [31:0]     mot_angle;
    logic [7:0]      mot_target;
    longint unsigned mot_speed;
    bit              mot_moving, mot_pressed;
    logic [31:0]     mot_idle;

    servo_out_t expected_results[$];
    int         mismatches = 0;
    bit         quiet = 1'b0;   // set near the end: no more idling on either side
    int         cmds_sent = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void rest_motion();
        mot_angle = {8'd0, cal_released, 16'd0};
        mot_target = cal_released;
        mot_speed = 0;
        mot_moving = 0;
        mot_pressed = 0;
        mot_idle = 0;
    endfunction

    function automatic void apply_cfg(cfg_reg_t idx, logic [31:0] v);
        case (idx)
            REG_PRESSED:   cal_pressed = v[7:0];
            REG_RELEASED:  cal_released = v[7:0];
            REG_SPEED:     cal_speed = v[15:0];
            REG_ACCEL:     cal_accel = v[19:0];
            REG_DET_EN:    cal_det_en = v[0];
            REG_DET_DLY:   cal_delay = v[15:0];
            REG_MIN_PULSE: cal_min_pulse = v[11:0];
            REG_MAX_PULSE: cal_max_pulse = v[11:0];
            default: ;
        endcase
        rest_motion();
    endfunction

    // Bitwise integer square root, rounded down.
    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v -= root + bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    // One tick of the motion profile: accelerate, cap at the speed limit and
    // at the stopping speed, step toward the target, snap, then clamp.
    function automatic void advance_profile(logic [15:0] ms);
        longint unsigned vmax, acc, tq, dist_q, stop, speed, step, lo, hi;
        bit up;
        if (ms == 0) return;
        if (!mot_moving) begin
            if (mot_idle < IDLE_CAP) mot_idle += 32'(ms);
            return;
        end
        vmax = longint'(cal_speed != 0 ? cal_speed : DEF_SPEED) << 8;
        acc = 64'(cal_accel != 0 ? cal_accel : DEF_ACCEL);
        tq = longint'(mot_target) << 16;
        up = tq >= mot_angle;
        dist_q = up ? tq - mot_angle : mot_angle - tq;
        stop = sqrt_floor(2 * acc * dist_q);
        speed = mot_speed + (acc * ms * 256) / 1000;
        if (speed > vmax) speed = vmax;
        if (speed > stop) speed = stop;
        step = (speed * ms * 256 + 999) / 1000;
        if (step >= dist_q) begin
            mot_angle = 32'(tq);
            mot_speed = 0;
            mot_moving = 0;
            mot_idle = 0;
        end else begin
            mot_angle = 32'(up ? mot_angle + step : mot_angle - step);
            mot_speed = speed;
        end
        lo = longint'(cal_pressed < cal_released ? cal_pressed : cal_released) << 16;
        hi = longint'(cal_pressed > cal_released ? cal_pressed : cal_released) << 16;
        if (mot_angle < lo) mot_angle = 32'(lo);
        if (mot_angle > hi) mot_angle = 32'(hi);
    endfunction

    // Pulse width with round-half-up; angles past 180 degrees saturate.
    function automatic logic [11:0] angle_to_pulse();
        longint a, span, num;
        a = longint'(mot_angle);
        if (INVERT) a = longint'(DEG180_Q16) - a;
        if (a < 0) a = 0;
        if (a > longint'(DEG180_Q16)) a = longint'(DEG180_Q16);
        span = longint'(cal_max_pulse) - longint'(cal_min_pulse);
        num = longint'(cal_min_pulse) * DEG180_Q16 + a * span + DEG180_Q16 / 2;
        if (num < 0) num = 0;
        return 12'(num / DEG180_Q16);
    endfunction

    function automatic servo_out_t predict_servo(mode_t m, bit pr, logic [15:0] ms);
        servo_out_t r;
        logic [31:0] tq, d;
        case (m)
            MODE_TICK: advance_profile(ms);
            MODE_TARGET: begin
                mot_pressed = pr;
                mot_target = pr ? cal_pressed : cal_released;
                tq = {8'd0, mot_target, 16'd0};
                d = tq >= mot_angle ? tq - mot_angle : mot_angle - tq;
                // Soft threshold: small changes only record the target.
                if (d > SOFT_THRESH) begin
                    mot_moving = 1;
                    mot_idle = 0;
                end
            end
            MODE_FORCE: begin
                mot_pressed = pr;
                mot_target = pr ? cal_pressed : cal_released;
                mot_angle = {8'd0, mot_target, 16'd0};
                mot_speed = 0;
                mot_moving = 0;
                mot_idle = 0;
            end
            default: ;
        endcase
        r.pulse_us = angle_to_pulse();
        r.angle_now = mot_angle[23:0];
        r.in_motion = mot_moving;
        r.is_pressed = mot_pressed;
        r.detach_request = cal_det_en && !mot_moving && mot_idle >= cal_delay;
        return r;
    endfunction

    // Drives one command transaction and records its expected result once
    // the block has taken it.
    task automatic send_cmd(mode_t m, bit pr, logic [15:0] ms, bit typed = 0,
                            servo_out_t want = '{default: 0});
        servo_out_t p;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= m;
        s_tdata <= {7'd0, ms, pr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = predict_servo(m, pr, ms);
        expected_results.push_back(typed ? want : p);
        cmds_sent++;
        if (cmds_sent > TOTAL_CMDS - QUIET_TAIL) quiet = 1'b1;
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that ends the access cycle.
    task automatic cfg_write(cfg_reg_t idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apply_cfg(idx, v);
    endtask

    // Waits until every queued result has come back, so a write finds the
    // block at rest.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic configure(logic [7:0] pa, logic [7:0] ra, logic [15:0] spd,
                             logic [19:0] acc, bit den, logic [15:0] dly,
                             logic [11:0] minp, logic [11:0] maxp);
        drain();
        cfg_write(REG_MIN_PULSE, 32'(minp));
        cfg_write(REG_MAX_PULSE, 32'(maxp));
        cfg_write(REG_SPEED, 32'(spd));
        cfg_write(REG_ACCEL, 32'(acc));
        cfg_write(REG_DET_EN, 32'(den));
        cfg_write(REG_DET_DLY, 32'(dly));
        cfg_write(REG_PRESSED, 32'(pa));
        cfg_write(REG_RELEASED, 32'(ra));
    endtask

    // Tick lengths lean short so motion takes several ticks, with the odd
    // long one to reach every bit of the field.
    function automatic logic [15:0] pick_ms();
        int sel = $urandom_range(0, 9);
        if (sel < 7) return 16'($urandom_range(1, 20));
        if (sel < 9) return 16'($urandom_range(1, 300));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Result side: random stall bursts, none in the closing stretch.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        servo_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result transaction", m_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[11:0] !== want.pulse_us)
                    report_mismatch("pulse_us", m_tdata[11:0], want.pulse_us);
                if (m_tdata[35:12] !== want.angle_now)
                    report_mismatch("angle_now", m_tdata[35:12], want.angle_now);
                if (m_tdata[36] !== want.in_motion)
                    report_mismatch("in_motion", m_tdata[36], want.in_motion);
                if (m_tdata[37] !== want.is_pressed)
                    report_mismatch("is_pressed", m_tdata[37], want.is_pressed);
                if (m_tdata[38] !== want.detach_request)
                    report_mismatch("detach_request", m_tdata[38], want.detach_request);
            end
        end
    end

    // Directed rows at reset settings: both angles are zero, so nothing can
    // move and the pulse sits at the 500 us default.
    cmd_row_t reset_rows[6] = '{
        '{MODE_NONE,   1'b1, 16'hFFFF, 1'b1, '{500, 0, 0, 0, 0}},
        '{MODE_TICK,   1'b0, 16'h0000, 1'b1, '{500, 0, 0, 0, 0}},
        '{MODE_TICK,   1'b1, 16'hFFFF, 1'b1, '{500, 0, 0, 0, 0}},
        '{MODE_TARGET, 1'b1, 16'h0000, 1'b1, '{500, 0, 0, 1, 0}},
        '{MODE_FORCE,  1'b0, 16'hFFFF, 1'b1, '{500, 0, 0, 0, 0}},
        '{MODE_TARGET, 1'b0, 16'h0001, 1'b1, '{500, 0, 0, 0, 0}}
    };

    // Directed rows over full travel: slow starts, a huge tick that snaps,
    // idle counting into the detach request, a target already reached,
    // forced jumps and the unused mode.
    cmd_row_t travel_rows[16] = '{
        '{MODE_TARGET, 1'b1, 16'd0,     1'b0, '{default: 0}},
        '{MODE_TICK,   1'b0, 16'd1,     1'b0, '{default: 0}},
        '{MODE_TICK,   1'b0, 16'd3,     1'b0, '{default: 0}},
        '{MODE_TICK,   1'b0, 16'd0,     1'b0, '{default: 0}},
        '{MODE_TICK,   1'b0, 16'hFFFF,  1'b0, '{default: 0}},
        '{MODE_TICK,   1'b0, 16'd2,     1'b0, '{default: 0}},
        '{MODE_TICK,   1'b0, 16'd10,    1'b0, '{default: 0}},
        '{MODE_TARGET, 1'b1, 16'd0,     1'b0, '{default: 0}},
        '{MODE_NONE,   1'b0, 16'd7,     1'b0, '{default: 0}},
        '{MODE_TARGET, 1'b0, 16'd0,     1'b0, '{default: 0}},
        '{MODE_TICK,   1'b0, 16'd5,     1'b0, '{default: 0}},
        '{MODE_FORCE,  1'b1, 16'd0,     1'b0, '{default: 0}},
        '{MODE_TARGET, 1'b0, 16'd0,     1'b0, '{default: 0}},
        '{MODE_TICK,   1'b0, 16'd20,    1'b0, '{default: 0}},
        '{MODE_FORCE,  1'b0, 16'hAAAA,  1'b0, '{default: 0}},
        '{MODE_TICK,   1'b0, 16'h5555,  1'b0, '{default: 0}}
    };

    initial begin
        int phase;
        int phase_end;
        int ticks;
        cal_pressed = 0; cal_released = 0; cal_speed = 0; cal_accel = 0;
        cal_det_en = 0; cal_delay = 0; cal_min_pulse = 500; cal_max_pulse = 2500;
        rest_motion();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (reset_rows[i])
            send_cmd(reset_rows[i].mode, reset_rows[i].press, reset_rows[i].ms,
                     reset_rows[i].typed, reset_rows[i].want);

        // Full travel with reversed pulse limits and every default in force.
        configure(8'd180, 8'd0, 16'd0, 20'd0, 1'b1, 16'd5, 12'd4000, 12'd0);
        foreach (travel_rows[i])
            send_cmd(travel_rows[i].mode, travel_rows[i].press, travel_rows[i].ms);

        phase = 0;
        while (cmds_sent < TOTAL_CMDS) begin
            // Each phase starts from a new setting; the first few are the
            // extremes, including an angle past 180 degrees.
            case (phase)
                0: configure(8'd0, 8'd180, 16'hFFFF, 20'd1000000, 1'b1, 16'hFFFF,
                             12'd0, 12'd4000);
                1: configure(8'd255, 8'd0, 16'd1, 20'd1, 1'b1, 16'd0,
                             12'd4000, 12'd4000);
                2: configure(8'd180, 8'd179, 16'd0, 20'hFFFFF, 1'b0, 16'd1,
                             12'hFFF, 12'd0);
                default: configure(8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                                : $urandom_range(0, 180)),
                                   8'($urandom_range(0, 180)),
                                   16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 1500)),
                                   20'($urandom_range(0, 3) == 0
                                       ? $urandom_range(0, 1000000)
                                       : $urandom_range(0, 20000)),
                                   1'($urandom()),
                                   16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 100)),
                                   12'($urandom_range(0, 4000)),
                                   12'($urandom_range(0, 4000)));
            endcase
            phase++;
            phase_end = cmds_sent + 160;
            while (cmds_sent < phase_end && cmds_sent < TOTAL_CMDS) begin
                if ($urandom_range(0, 4) != 0) begin
                    // A move: pick a side, tick until it ends (at most 60 ticks), then idle a bit.
                    send_cmd(MODE_TARGET, 1'($urandom()), 16'($urandom_range(0, 65535)));
                    ticks = 0;
                    while (mot_moving && ticks < 60 && cmds_sent < TOTAL_CMDS) begin
                        send_cmd(MODE_TICK, 1'($urandom()), pick_ms());
                        ticks++;
                    end
                    repeat ($urandom_range(0, 3))
                        send_cmd(MODE_TICK, 1'($urandom()), pick_ms());
                end else begin
                    // Noise: any mode, any press, any tick length.
                    send_cmd(mode_t'($urandom_range(0, 3)), 1'($urandom()),
                             16'($urandom_range(0, 65535)));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (mismatches == 0) begin
            $display("servo_trapezoid_motion_profile test passed");
        end else begin
            $display("servo_trapezoid_motion_profile test failed");
        end
        $finish;
    end

    // Watchdog, far above the slowest correct run.
    initial begin
        #40_000_000;
        $display("servo_trapezoid_motion_profile test failed");
        $finish;
    end

endmodule
